[hdl/scd_pkg.sv]
// Shared types, register codes and the log2 feature functions of the
// scored best task select block. No dependencies.
`default_nettype none

package scd_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_COLD = 2'd0;
  localparam logic [1:0] REG_LOAD = 2'd1;
  localparam logic [1:0] REG_VOL  = 2'd2;
  localparam logic [1:0] REG_WAKE = 2'd3;

  // feature queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam int SCORE_W = 12;
  localparam int OPOS_W  = 10;

  typedef struct packed {
    logic [1:0] wc;
    logic [1:0] wl;
    logic [1:0] wv;
    logic [1:0] ww;
  } weights_t;

  // one classified candidate
  typedef struct packed {
    logic [7:0] f0;
    logic [7:0] f1;
    logic [6:0] f2;
    logic [7:0] f3;
    logic       mig;
    logic       last;
  } feat_t;

  // one result beat
  typedef struct packed {
    logic signed [SCORE_W-1:0] task_score;
    logic signed [SCORE_W-1:0] lead_score;
    logic [OPOS_W-1:0]         best_position;
    logic                      best_found;
    logic                      scan_done;
  } res_t;

  // held best state, exported for checks
  typedef struct packed {
    logic                      found;
    logic signed [SCORE_W-1:0] lead_score;
    logic [OPOS_W-1:0]         best_position;
    logic                      pos_zero;
  } bk_status_t;

  // fixed-point log2(v)+1 (0 for v=0): exponent code and two mantissa bits, wrapped to 8 bits
  function automatic logic [7:0] flog(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  lz;
    x  = v;
    lz = '0;
    if (x[63:32] == 32'd0) begin
      lz[5] = 1'b1;
      x     = {x[31:0], 32'd0};
    end
    if (x[63:48] == 16'd0) begin
      lz[4] = 1'b1;
      x     = {x[47:0], 16'd0};
    end
    if (x[63:56] == 8'd0) begin
      lz[3] = 1'b1;
      x     = {x[55:0], 8'd0};
    end
    if (x[63:60] == 4'd0) begin
      lz[2] = 1'b1;
      x     = {x[59:0], 4'd0};
    end
    if (x[63:62] == 2'd0) begin
      lz[1] = 1'b1;
      x     = {x[61:0], 2'd0};
    end
    if (x[63] == 1'b0) begin
      lz[0] = 1'b1;
      x     = {x[62:0], 1'b0};
    end
    if (v == 64'd0) begin
      return 8'd0;
    end
    return {6'd0 - lz, x[62:61]};
  endfunction

  // voluntary switch ratio clamped to 0..64
  function automatic logic [6:0] vol_ratio(input logic [31:0] vol, input logic [31:0] invol);
    logic [32:0]        total;
    logic [7:0]         lv;
    logic [7:0]         lt;
    logic signed [9:0]  r;
    total = {1'b0, vol} + {1'b0, invol};
    lv    = flog({32'd0, vol});
    lt    = flog({31'd0, total});
    r     = $signed({2'b00, lv}) - $signed({2'b00, lt}) + 10'sd64;
    if (total == 33'd0) begin
      return 7'd0;
    end
    if (r < 10'sd0) begin
      return 7'd0;
    end
    if (r > 10'sd64) begin
      return 7'd64;
    end
    return r[6:0];
  endfunction

endpackage

`default_nettype wire

[hdl/scd_front.sv]
// Front end: turns one candidate beat into its four log2 features.
// Depends on scd_pkg (feat_t, flog, vol_ratio).
`default_nettype none

module scd_front (
  input  wire logic [63:0] idle_time,
  input  wire logic [63:0] task_load,
  input  wire logic [31:0] voluntary_switches,
  input  wire logic [31:0] involuntary_switches,
  input  wire logic [31:0] wakee_flip_count,
  input  wire logic        migratable,
  input  wire logic        last_candidate,
  output scd_pkg::feat_t   feat
);

  logic [63:0] load_min1;
  logic [31:0] wakee_inc;

  // raise load to at least one, bump wakee count with wrap
  assign load_min1 = (task_load == 64'd0) ? 64'd1 : task_load;
  assign wakee_inc = wakee_flip_count + 32'd1;

  // classify
  always_comb begin
    feat.f0   = scd_pkg::flog(idle_time);
    feat.f1   = scd_pkg::flog(load_min1);
    feat.f2   = scd_pkg::vol_ratio(voluntary_switches, involuntary_switches);
    feat.f3   = scd_pkg::flog({32'd0, wakee_inc});
    feat.mig  = migratable;
    feat.last = last_candidate;
  end

endmodule

`default_nettype wire

[hdl/scd_queue.sv]
// Short feature queue that decouples the front end from the scoring back end.
// Depends on scd_pkg (feat_t, queue depth constants).
`default_nettype none

module scd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire scd_pkg::feat_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output scd_pkg::feat_t      pop_data
);

  scd_pkg::feat_t                 mem_r [scd_pkg::Q_DEPTH];
  logic [scd_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [scd_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [scd_pkg::Q_CNT_W-1:0]    count_r;
  logic [scd_pkg::Q_CNT_W-1:0]    count_nxt;
  logic                           push;
  logic                           pop;

  assign push_ready = (count_r != scd_pkg::Q_CNT_W'(scd_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hdl/scd_back.sv]
// Back end: weights the features, tracks the best migratable candidate of the
// scan and holds the result beat. Depends on scd_pkg.
`default_nettype none

module scd_back #(
  parameter int MAX_SCAN_LENGTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scd_pkg::weights_t weights,
  input  wire logic              feat_valid,
  output logic                   feat_ready,
  input  wire scd_pkg::feat_t    feat,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output scd_pkg::res_t          res,
  output scd_pkg::bk_status_t    status
);

  localparam int POS_W = $clog2(MAX_SCAN_LENGTH);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SCAN_LENGTH - 1);

  logic signed [scd_pkg::SCORE_W-1:0] lead_score_r;
  logic [POS_W-1:0]                   best_pos_r;
  logic                               found_r;
  logic [POS_W-1:0]                   scan_pos_r;
  logic                               out_valid_r;
  scd_pkg::res_t                      out_data_r;

  logic [9:0]                         p0;
  logic [9:0]                         p1;
  logic [9:0]                         p2;
  logic [9:0]                         p3;
  logic signed [scd_pkg::SCORE_W-1:0] score;
  logic                               pop;
  logic                               win;
  logic signed [scd_pkg::SCORE_W-1:0] lead_score_nxt;
  logic [POS_W-1:0]                   best_pos_nxt;
  logic                               found_nxt;

  // weighted score
  assign p0    = weights.wc * feat.f0;
  assign p1    = weights.wl * feat.f1;
  assign p2    = weights.wv * {1'b0, feat.f2};
  assign p3    = weights.ww * feat.f3;
  assign score = $signed({2'b00, p0}) + $signed({2'b00, p1})
               + $signed({2'b00, p2}) - $signed({2'b00, p3});

  // take a feature beat when the result slot is free or draining
  assign pop        = feat_valid & (~out_valid_r | res_ready);
  assign feat_ready = ~out_valid_r | res_ready;

  // compare against the running best; equal scores keep the earlier one
  assign win            = feat.mig & (~found_r | (score > lead_score_r));
  assign lead_score_nxt = win ? score : lead_score_r;
  assign best_pos_nxt   = win ? scan_pos_r : best_pos_r;
  assign found_nxt      = found_r | win;

  // hold best state, clear at the end of a scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_score_r <= '0;
      best_pos_r   <= '0;
      found_r      <= 1'b0;
      scan_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= pop | (out_valid_r & ~res_ready);
      if (pop) begin
        if (feat.last) begin
          lead_score_r <= '0;
          best_pos_r   <= '0;
          found_r      <= 1'b0;
          scan_pos_r   <= '0;
        end else begin
          lead_score_r <= lead_score_nxt;
          best_pos_r   <= best_pos_nxt;
          found_r      <= found_nxt;
          if (scan_pos_r != POS_MAX) begin
            scan_pos_r <= scan_pos_r + 1'b1;
          end
        end
      end
    end
  end

  // load the result beat
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.task_score    <= score;
      out_data_r.lead_score    <= found_nxt ? lead_score_nxt : '0;
      out_data_r.best_position <= found_nxt ? scd_pkg::OPOS_W'(best_pos_nxt) : '0;
      out_data_r.best_found    <= found_nxt;
      out_data_r.scan_done     <= feat.last;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_data_r;

  assign status.found         = found_r;
  assign status.lead_score    = lead_score_r;
  assign status.best_position = scd_pkg::OPOS_W'(best_pos_r);
  assign status.pos_zero      = (scan_pos_r == '0);

endmodule

`default_nettype wire

[hdl/scored_best_task_select_core.sv]
// Scored best task select: each input beat is one candidate task of a scan.
// The block forms four log2 features (cache coldness, load, voluntary switch
// ratio, wakee penalty), scores them with the four 2-bit weights and reports,
// on every result beat, the item's score and the best migratable score of the
// scan so far with its scan position; the beat for the last candidate carries
// tlast and clears the scan state. One candidate is taken every cycle while
// in_tready is high; a result passes the four-entry queue, then the scoring
// and best-compare stage into the output register. Scan positions saturate
// at MAX_SCAN_LENGTH-1. Weights are written over the APB port at byte
// addresses 0, 4, 8, 12; the user must write them only while idle, which the
// block does not enforce. Depends on scd_pkg, scd_front, scd_queue, scd_back.
`default_nettype none

module scored_best_task_select_core #(
  parameter int MAX_SCAN_LENGTH = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata fields, low bit up: idle_time[63:0], task_load[127:64],
  // voluntary_switches[159:128], involuntary_switches[191:160],
  // wakee_flip_count[223:192]
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [223:0] in_tdata,
  // in_tuser fields: migratable[0]
  input  wire logic [0:0]   in_tuser,
  input  wire logic         in_tlast,
  // out_tdata fields, low bit up: task_score[11:0], lead_score[23:12],
  // best_position[33:24], best_found[34], zero pad[39:35]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [39:0]       out_tdata,
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  scd_pkg::weights_t   weights_r;
  scd_pkg::weights_t   weights_nxt;
  scd_pkg::feat_t      front_feat;
  scd_pkg::feat_t      q_data;
  logic                q_valid;
  logic                q_pop;
  scd_pkg::res_t       res;
  scd_pkg::bk_status_t bk_st;
  logic                cfg_wr;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    weights_nxt = weights_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        scd_pkg::REG_COLD: weights_nxt.wc = cfg_pwdata[1:0];
        scd_pkg::REG_LOAD: weights_nxt.wl = cfg_pwdata[1:0];
        scd_pkg::REG_VOL:  weights_nxt.wv = cfg_pwdata[1:0];
        scd_pkg::REG_WAKE: weights_nxt.ww = cfg_pwdata[1:0];
        default:           weights_nxt    = weights_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r.wc <= 2'd1;
      weights_r.wl <= 2'd2;
      weights_r.wv <= 2'd1;
      weights_r.ww <= 2'd1;
    end else begin
      weights_r <= weights_nxt;
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr[3:2])
      scd_pkg::REG_COLD: cfg_prdata = {30'd0, weights_r.wc};
      scd_pkg::REG_LOAD: cfg_prdata = {30'd0, weights_r.wl};
      scd_pkg::REG_VOL:  cfg_prdata = {30'd0, weights_r.wv};
      scd_pkg::REG_WAKE: cfg_prdata = {30'd0, weights_r.ww};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // classify candidates
  scd_front u_front (
    .idle_time            (in_tdata[63:0]),
    .task_load            (in_tdata[127:64]),
    .voluntary_switches   (in_tdata[159:128]),
    .involuntary_switches (in_tdata[191:160]),
    .wakee_flip_count     (in_tdata[223:192]),
    .migratable           (in_tuser[0]),
    .last_candidate       (in_tlast),
    .feat                 (front_feat)
  );

  // decouple front and back
  scd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (front_feat),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  // score and track best
  scd_back #(
    .MAX_SCAN_LENGTH (MAX_SCAN_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .weights    (weights_r),
    .feat_valid (q_valid),
    .feat_ready (q_pop),
    .feat       (q_data),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res),
    .status     (bk_st)
  );

  // pack result beat
  assign out_tdata = {5'd0, res.best_found, res.best_position,
                      res.lead_score, res.task_score};
  assign out_tlast = res.scan_done;

`ifndef ASSERT_OFF
  // back end state is cleared after the last candidate of a scan
  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_pop && q_data.last) |=> (!bk_st.found && bk_st.pos_zero))
    else $error("scan state not cleared after last candidate");

  // without a found candidate the held best stays zero
  a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !bk_st.found |-> (bk_st.lead_score == '0 && bk_st.best_position == '0))
    else $error("held best nonzero while nothing found");

  // a beat with nothing found carries zero best fields
  a_found_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[34]) |-> (out_tdata[33:12] == 22'd0))
    else $error("best fields nonzero in a beat with nothing found");

  // the held best only grows within a scan
  a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_st.found && q_valid && q_pop && !q_data.last)
      |=> ($signed(bk_st.lead_score) >= $signed($past(bk_st.lead_score))))
    else $error("held best score decreased within a scan");
`endif

endmodule

`default_nettype wire
